### hw/rtl/mstj_pkg.sv
// shared constants and types for the maze spanning tree joiner
`timescale 1ns / 1ps

package mstj_pkg;

    // grid geometry
    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CELL_W      = $clog2(CELL_COUNT);

    // configuration register geometry
    localparam int CFG_W       = 6;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // request op codes
    typedef enum logic [1:0] {
        OP_JOIN  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NB_OFF   = 2'd1,
        ST_SAME_SET = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    // join direction
    localparam logic DIR_UP    = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    // one stored cell
    typedef struct packed {
        logic              right_open;
        logic              up_open;
        logic [CELL_W-1:0] label;
    } cell_word_t;

    localparam int WORD_W = $bits(cell_word_t);

endpackage

### hw/rtl/maze_spanning_tree_joiner_top.sv
// Maze spanning tree joiner: a grid of cells with wall flags and set labels, joined one
// request at a time. After reset, and for every clear request, the block sweeps all 1024
// cells of the cell memory, one cell per cycle, and takes no request meanwhile; a clear
// answers when its sweep ends. A request for a cell outside the grid goes from idle
// straight to the done state, a read or a join whose neighbor is off the grid first reads
// its cell, and a join refused because both cells already share a set also reads the
// neighbor. A join that opens a wall reads both cells, then rewrites the labels of all
// 1024 cells through the single-read, single-write cell memory, one cell per cycle, and answers.
// One request is in work at a time; a finished result waits in the output register.
`timescale 1ns / 1ps

module maze_spanning_tree_joiner_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // cell_x[4:0], cell_y[9:5], direction[10], zero
    input  logic [1:0]                        s_tuser,   // op[1:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // status[1:0], up_open[2], right_open[3], zero
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mstj_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mstj_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mstj_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CELL_W = mstj_pkg::CELL_W;
    localparam int CFG_W  = mstj_pkg::CFG_W;
    localparam int COL_W  = mstj_pkg::COL_W;
    localparam int ROW_W  = mstj_pkg::ROW_W;
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(mstj_pkg::CELL_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_NB,
        S_SCAN,
        S_DONE
    } state_t;

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // sequencer state
    state_t                state_reg, state_next;
    logic [CELL_W-1:0]     cnt_reg, cnt_next;
    logic                  clear_reply_reg, clear_reply_next;
    mstj_pkg::op_t         op_reg, op_next;
    logic                  dir_reg, dir_next;
    logic                  off_reg, off_next;
    logic [CELL_W-1:0]     cell_reg, cell_next;
    mstj_pkg::cell_word_t  cell_word_reg, cell_word_next;
    logic [CELL_W-1:0]     new_label_reg, new_label_next;
    mstj_pkg::status_t     res_status_reg, res_status_next;
    logic                  res_up_reg, res_up_next;
    logic                  res_right_reg, res_right_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    mstj_pkg::status_t     out_status_reg, out_status_next;
    logic                  out_up_reg, out_up_next;
    logic                  out_right_reg, out_right_next;

    // memory ports
    logic                  mem_we;
    logic [CELL_W-1:0]     mem_waddr;
    mstj_pkg::cell_word_t  mem_wdata;
    logic [CELL_W-1:0]     mem_raddr;
    mstj_pkg::cell_word_t  mem_rdata;

    // request fields
    logic [COL_W-1:0]      in_x;
    logic [ROW_W-1:0]      in_y;
    logic                  in_dir;
    mstj_pkg::op_t         in_op;
    logic [CELL_W-1:0]     in_cell;
    logic [CFG_W-1:0]      w_eff;
    logic [CFG_W-1:0]      h_eff;
    logic                  in_outside;
    logic                  in_nb_off;
    logic [CELL_W-1:0]     nb_cell;
    logic                  accept;
    logic                  out_free;

    assign in_x    = s_tdata[COL_W-1:0];
    assign in_y    = s_tdata[COL_W+ROW_W-1:COL_W];
    assign in_dir  = s_tdata[COL_W+ROW_W];
    assign in_op   = mstj_pkg::op_t'(s_tuser);
    assign in_cell = CELL_W'(CELL_W'(in_y) * CELL_W'(mstj_pkg::MAX_COLUMNS)) + CELL_W'(in_x);

    // sizes in use, saturated to the built grid
    assign w_eff = (width_reg > CFG_W'(mstj_pkg::MAX_COLUMNS))
                   ? CFG_W'(mstj_pkg::MAX_COLUMNS) : width_reg;
    assign h_eff = (height_reg > CFG_W'(mstj_pkg::MAX_ROWS))
                   ? CFG_W'(mstj_pkg::MAX_ROWS) : height_reg;

    // grid checks on the incoming request
    assign in_outside = (CFG_W'(in_x) >= w_eff) || (CFG_W'(in_y) >= h_eff);
    assign in_nb_off  = (in_dir == mstj_pkg::DIR_UP) ? (in_y == '0)
                        : ((CFG_W'(in_x) + CFG_W'(1)) >= w_eff);

    assign nb_cell = (dir_reg == mstj_pkg::DIR_UP)
                     ? cell_reg - CELL_W'(mstj_pkg::MAX_COLUMNS)
                     : cell_reg + CELL_W'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // apb port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mstj_pkg::REG_HEIGHT)
                    ? mstj_pkg::APB_DATA_W'(height_reg)
                    : mstj_pkg::APB_DATA_W'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(32);
            height_reg <= CFG_W'(32);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == mstj_pkg::REG_HEIGHT)
            begin
                height_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // cell memory
    mstj_ram #(
        .DATA_W (mstj_pkg::WORD_W),
        .DEPTH  (mstj_pkg::CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        clear_reply_next = clear_reply_reg;
        op_next          = op_reg;
        dir_next         = dir_reg;
        off_next         = off_reg;
        cell_next        = cell_reg;
        cell_word_next   = cell_word_reg;
        new_label_next   = new_label_reg;
        res_status_next  = res_status_reg;
        res_up_next      = res_up_reg;
        res_right_next   = res_right_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_up_next      = out_up_reg;
        out_right_next   = out_right_reg;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = mem_rdata;
        mem_raddr        = cell_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{right_open: 1'b0, up_open: 1'b0, label: cnt_reg};
                cnt_next  = cnt_reg + CELL_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    res_status_next = mstj_pkg::ST_OK;
                    res_up_next     = 1'b0;
                    res_right_next  = 1'b0;
                    state_next      = clear_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                mem_raddr = in_cell;
                if (accept)
                begin
                    op_next   = in_op;
                    dir_next  = in_dir;
                    off_next  = in_nb_off;
                    cell_next = in_cell;
                    if (in_op == mstj_pkg::OP_CLEAR)
                    begin
                        cnt_next         = '0;
                        clear_reply_next = 1'b1;
                        state_next       = S_CLEAR;
                    end
                    else if (in_outside)
                    begin
                        res_status_next = mstj_pkg::ST_OUTSIDE;
                        res_up_next     = 1'b0;
                        res_right_next  = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CELL;
                    end
                end
            end
            S_CELL:
            begin
                // cell word is back; fetch the neighbor if a join can go on
                cell_word_next = mem_rdata;
                mem_raddr      = nb_cell;
                res_up_next    = mem_rdata.up_open;
                res_right_next = mem_rdata.right_open;
                if (op_reg == mstj_pkg::OP_JOIN && !off_reg)
                begin
                    state_next = S_NB;
                end
                else
                begin
                    res_status_next = (op_reg == mstj_pkg::OP_JOIN)
                                      ? mstj_pkg::ST_NB_OFF : mstj_pkg::ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_NB:
            begin
                // neighbor word is back; start the relabel sweep at cell 0
                mem_raddr      = '0;
                new_label_next = mem_rdata.label;
                if (mem_rdata.label == cell_word_reg.label)
                begin
                    res_status_next = mstj_pkg::ST_SAME_SET;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // write back cell cnt, read cell cnt+1
                mem_we    = 1'b1;
                mem_raddr = cnt_reg + CELL_W'(1);
                if (mem_rdata.label == cell_word_reg.label)
                begin
                    mem_wdata.label = new_label_reg;
                end
                if (cnt_reg == cell_reg)
                begin
                    if (dir_reg == mstj_pkg::DIR_UP)
                    begin
                        mem_wdata.up_open = 1'b1;
                    end
                    else
                    begin
                        mem_wdata.right_open = 1'b1;
                    end
                end
                cnt_next = cnt_reg + CELL_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    res_status_next = mstj_pkg::ST_OK;
                    res_up_next     = cell_word_reg.up_open || (dir_reg == mstj_pkg::DIR_UP);
                    res_right_next  = cell_word_reg.right_open
                                      || (dir_reg == mstj_pkg::DIR_RIGHT);
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_up_next     = res_up_reg;
                    out_right_next  = res_right_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            clear_reply_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            clear_reply_reg <= clear_reply_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        dir_reg        <= dir_next;
        off_reg        <= off_next;
        cell_reg       <= cell_next;
        cell_word_reg  <= cell_word_next;
        new_label_reg  <= new_label_next;
        res_status_reg <= res_status_next;
        res_up_reg     <= res_up_next;
        res_right_reg  <= res_right_next;
        out_status_reg <= out_status_next;
        out_up_reg     <= out_up_next;
        out_right_reg  <= out_right_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_right_reg, out_up_reg, out_status_reg};

    // memory is written only by the clear sweep and the relabel sweep
    a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN || state_reg == S_CLEAR))
        else $error("cell memory written outside a sweep");

    // a taken request holds off the next one
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

    // the relabel sweep starts at the first cell
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB && state_next == S_SCAN) |=> (cnt_reg == '0))
        else $error("relabel sweep does not start at cell 0");

    // an outside-grid answer carries closed walls
    a_outside_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == mstj_pkg::ST_OUTSIDE) |-> (!out_up_reg && !out_right_reg))
        else $error("outside-grid answer with open wall flags");

endmodule

### hw/rtl/mstj_ram.sv
// simple dual-port ram with one write port and one registered read port
`timescale 1ns / 1ps

module mstj_ram #(
    parameter int DATA_W = 12,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### tb/maze_spanning_tree_joiner_top_tb.sv
// self-checking testbench for the maze spanning tree joiner, clocked driver and monitor
`timescale 1ns / 1ps

module maze_spanning_tree_joiner_top_tb;

    localparam int LIMIT_CYCLES  = 2_500_000;
    localparam int SETTLE_CYCLES = 1100;

    // one request as queued for the driver; pause marks a hold until all results are back
    typedef struct {
        mstj_pkg::op_t op;
        logic [4:0]    x;
        logic [4:0]    y;
        logic          dir;
        logic          pause;
    } maze_req_t;

    typedef struct {
        mstj_pkg::status_t status;
        logic              up_open;
        logic              right_open;
    } maze_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // cell_x[4:0], cell_y[9:5], direction[10], zero
    logic [1:0]  s_tuser = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // status[1:0], up_open[2], right_open[3], zero

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mstj_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [mstj_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mstj_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // shadow of the grid and the size registers
    logic                        shadow_up[mstj_pkg::CELL_COUNT];
    logic                        shadow_right[mstj_pkg::CELL_COUNT];
    logic [mstj_pkg::CELL_W-1:0] shadow_label[mstj_pkg::CELL_COUNT];
    int unsigned                 cols_reg = 32;
    int unsigned                 rows_reg = 32;

    maze_req_t pending_reqs[$];
    maze_res_t expected_results[$];
    maze_req_t in_flight;

    int  send_gap = 0;
    int  recv_stall = 0;
    bit  quiet = 1'b0;
    int  errors = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  walls_opened = 0;
    int  settings_used = 0;
    longint cycle_count = 0;

    maze_spanning_tree_joiner_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // close every wall and give each cell its own label
    function automatic void clear_shadow_grid();
        for (int i = 0; i < mstj_pkg::CELL_COUNT; i++)
        begin
            shadow_up[i]    = 1'b0;
            shadow_right[i] = 1'b0;
            shadow_label[i] = i[mstj_pkg::CELL_W-1:0];
        end
    endfunction

    // columns and rows in use, oversized values act as the built maximum
    function automatic int cols_in_use();
        return (cols_reg > mstj_pkg::MAX_COLUMNS) ? mstj_pkg::MAX_COLUMNS : cols_reg;
    endfunction

    function automatic int rows_in_use();
        return (rows_reg > mstj_pkg::MAX_ROWS) ? mstj_pkg::MAX_ROWS : rows_reg;
    endfunction

    // apply one request to the shadow grid and return the answer it gets
    function automatic maze_res_t apply_maze_request(maze_req_t r);
        maze_res_t                   o;
        int                          w;
        int                          h;
        int                          cell_idx;
        int                          nb;
        logic [mstj_pkg::CELL_W-1:0] old_lbl;
        logic [mstj_pkg::CELL_W-1:0] new_lbl;
        o.status     = mstj_pkg::ST_OK;
        o.up_open    = 1'b0;
        o.right_open = 1'b0;
        w = cols_in_use();
        h = rows_in_use();
        if (r.op == mstj_pkg::OP_CLEAR)
        begin
            clear_shadow_grid();
            return o;
        end
        if (int'(r.x) >= w || int'(r.y) >= h)
        begin
            o.status = mstj_pkg::ST_OUTSIDE;
            return o;
        end
        cell_idx = int'(r.y) * mstj_pkg::MAX_COLUMNS + int'(r.x);
        if (r.op == mstj_pkg::OP_JOIN)
        begin
            if (r.dir == mstj_pkg::DIR_UP && r.y == 0)
                o.status = mstj_pkg::ST_NB_OFF;
            else if (r.dir == mstj_pkg::DIR_RIGHT && int'(r.x) + 1 >= w)
                o.status = mstj_pkg::ST_NB_OFF;
            else
            begin
                nb = (r.dir == mstj_pkg::DIR_UP) ? cell_idx - mstj_pkg::MAX_COLUMNS
                                                 : cell_idx + 1;
                old_lbl = shadow_label[cell_idx];
                new_lbl = shadow_label[nb];
                if (old_lbl == new_lbl)
                    o.status = mstj_pkg::ST_SAME_SET;
                else
                begin
                    if (r.dir == mstj_pkg::DIR_UP)
                        shadow_up[cell_idx] = 1'b1;
                    else
                        shadow_right[cell_idx] = 1'b1;
                    // merge the whole set, cells beyond the sizes in use included
                    for (int i = 0; i < mstj_pkg::CELL_COUNT; i++)
                        if (shadow_label[i] == old_lbl)
                            shadow_label[i] = new_lbl;
                    walls_opened++;
                end
            end
        end
        o.up_open    = shadow_up[cell_idx];
        o.right_open = shadow_right[cell_idx];
        return o;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_maze_request(in_flight));
                requests_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && pending_reqs[0].pause)
                begin
                    if (expected_results.size() == 0 && !s_tvalid)
                        void'(pending_reqs.pop_front());
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_flight = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, in_flight.dir, in_flight.y, in_flight.x};
                    s_tuser  <= in_flight.op;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        maze_res_t got;
        maze_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status     = mstj_pkg::status_t'(m_tdata[1:0]);
                got.up_open    = m_tdata[2];
                got.right_open = m_tdata[3];
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, actual status %0d up %0b right %0b",
                             $time, got.status, got.up_open, got.right_open);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.up_open !== want.up_open)
                    begin
                        errors++;
                        $display("%0t: up_open expected %0b actual %0b",
                                 $time, want.up_open, got.up_open);
                    end
                    if (got.right_open !== want.right_open)
                    begin
                        errors++;
                        $display("%0t: right_open expected %0b actual %0b",
                                 $time, want.right_open, got.right_open);
                    end
                end
            end
            // receiver back-pressure
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                recv_stall = ($urandom_range(0, 99) < 20) ? pick_gap() : 0;
                m_tready <= (recv_stall == 0);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run limit reached, %0d results still due",
                     $time, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(input mstj_pkg::op_t op, input int x, input int y, input logic dir);
        maze_req_t r;
        r.op    = op;
        r.x     = x[4:0];
        r.y     = y[4:0];
        r.dir   = dir;
        r.pause = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // hold the sender until every result is back
    task automatic add_pause();
        maze_req_t r;
        r.op    = mstj_pkg::OP_READ;
        r.x     = '0;
        r.y     = '0;
        r.dir   = 1'b0;
        r.pause = 1'b1;
        pending_reqs.push_back(r);
    endtask

    // wait for the block to drain, then for a clear sweep to finish
    task automatic settle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // two-phase register write
    task automatic write_reg(input logic idx, input int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mstj_pkg::REG_WIDTH)
            cols_reg = value & 32'h3f;
        else
            rows_reg = value & 32'h3f;
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows);
        settle();
        write_reg(mstj_pkg::REG_WIDTH, cols);
        write_reg(mstj_pkg::REG_HEIGHT, rows);
        settings_used++;
    endtask

    // random coordinate, inside the grid in use where it has any cells
    function automatic int pick_coord(input int lim);
        return (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 31);
    endfunction

    // mostly joins inside the grid, some reads, a little noise and the odd clear
    task automatic fill_random_phase(input int count);
        int w;
        int h;
        int r;
        int pause_at;
        w = cols_in_use();
        h = rows_in_use();
        pause_at = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (i == pause_at)
                add_pause();
            if (r < 68)
                add_req(mstj_pkg::OP_JOIN, pick_coord(w), pick_coord(h),
                        1'($urandom_range(0, 1)));
            else if (r < 80)
                add_req(mstj_pkg::OP_READ, pick_coord(w), pick_coord(h),
                        1'($urandom_range(0, 1)));
            else if (r < 83)
                add_req(mstj_pkg::OP_SPARE, pick_coord(w), pick_coord(h),
                        1'($urandom_range(0, 1)));
            else if (r < 93)
                add_req(mstj_pkg::op_t'($urandom_range(0, 3) == 2 ? 1 : $urandom_range(0, 3)),
                        $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1)));
            else if (r < 95)
                add_req(mstj_pkg::OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1)));
            else if (r < 98)
                add_req(mstj_pkg::OP_JOIN, (w > 0) ? w - 1 : 0, pick_coord(h),
                        mstj_pkg::DIR_RIGHT);
            else
                add_req(mstj_pkg::OP_JOIN, pick_coord(w), 0, mstj_pkg::DIR_UP);
        end
    endtask

    initial
    begin
        int phase_cols[11];
        int phase_rows[11];
        phase_cols = '{32, 2, 4, 63, 1, 8, 16, 2, 32, 5, 32};
        phase_rows = '{32, 2, 3, 40, 5, 8, 32, 32, 2, 7, 32};
        clear_shadow_grid();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: border refusals, a small cycle refused, reads, spare op, clear
        add_req(mstj_pkg::OP_JOIN, 0, 0, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 31, 5, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_JOIN, 31, 0, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 31, 31, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 31, 31, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 30, 31, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_JOIN, 30, 30, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_JOIN, 30, 31, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_READ, 31, 31, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_SPARE, 30, 31, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_READ, 0, 0, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_CLEAR, 31, 31, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_READ, 31, 31, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 0, 1, mstj_pkg::DIR_UP);

        // no columns at all: every cell lies outside
        set_grid(0, 5);
        add_req(mstj_pkg::OP_READ, 0, 0, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 0, 0, mstj_pkg::DIR_RIGHT);

        // single column, oversized rows
        set_grid(1, 40);
        add_req(mstj_pkg::OP_JOIN, 0, 3, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_JOIN, 0, 3, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_READ, 0, 31, mstj_pkg::DIR_UP);

        // oversized columns, two rows
        set_grid(63, 2);
        add_req(mstj_pkg::OP_JOIN, 31, 1, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 31, 0, mstj_pkg::DIR_RIGHT);
        add_req(mstj_pkg::OP_JOIN, 5, 2, mstj_pkg::DIR_UP);
        add_req(mstj_pkg::OP_JOIN, 30, 0, mstj_pkg::DIR_RIGHT);

        // random phases over a spread of grid sizes
        for (int p = 0; p < 11; p++)
        begin
            set_grid(phase_cols[p], phase_rows[p]);
            quiet = (p == 5);
            fill_random_phase(41);
        end

        settle();
        $display("sent %0d requests over %0d grid settings, checked %0d results",
                 requests_sent, settings_used, results_checked);
        $display("%0d walls opened, border, same-set, outside and clear cases included",
                 walls_opened);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/mstj_pkg.sv
hw/rtl/mstj_ram.sv
hw/rtl/maze_spanning_tree_joiner_top.sv
tb/maze_spanning_tree_joiner_top_tb.sv
